// ----- hdl/lvbs_pkg.sv -----
// Shared constants, types and helpers of the label volume bounds scanner.
package lvbs_pkg;

   localparam int LABEL_BITS     = 8;
   localparam int LABEL_COUNT    = 1 << LABEL_BITS;
   localparam int MAX_DIM        = 256;
   localparam int COORD_BITS     = $clog2(MAX_DIM);
   localparam int DIM_BITS       = COORD_BITS + 1;
   localparam int RING_DEPTH     = MAX_DIM * MAX_DIM;
   localparam int RING_ADDR_BITS = $clog2(RING_DEPTH);
   localparam int BOX_BITS       = 6 * COORD_BITS;
   localparam int CSR_IDX_BITS   = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_DIM_X = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIM_Y = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIM_Z = 2'd2;

   localparam logic OP_VOXEL = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [LABEL_BITS-1:0] LABEL_NONE = '0;

   localparam logic [DIM_BITS-1:0] DIM_MIN = DIM_BITS'(2);
   localparam logic [DIM_BITS-1:0] DIM_MAX = DIM_BITS'(MAX_DIM);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] x;
      logic [DIM_BITS-1:0] y;
      logic [DIM_BITS-1:0] z;
   } dims_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]     x;
      logic [COORD_BITS-1:0]     y;
      logic [COORD_BITS-1:0]     z;
      logic [RING_ADDR_BITS-1:0] addr;
   } pos_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] lo_x;
      logic [COORD_BITS-1:0] lo_y;
      logic [COORD_BITS-1:0] lo_z;
      logic [COORD_BITS-1:0] hi_x;
      logic [COORD_BITS-1:0] hi_y;
      logic [COORD_BITS-1:0] hi_z;
   } box_type;

   typedef struct packed {
      logic                  scan;
      logic                  clear;
      logic [LABEL_BITS-1:0] label;
      logic [LABEL_BITS-1:0] left;
      logic [LABEL_BITS-1:0] up;
      logic [LABEL_BITS-1:0] prev;
      logic                  left_ok;
      logic                  up_ok;
      logic                  prev_ok;
   } mark_cmd_type;

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
      logic [DIM_BITS-1:0] d;
      d = v;
      if (v < DIM_MIN) begin
         d = DIM_MIN;
      end else if (v > DIM_MAX) begin
         d = DIM_MAX;
      end
      return d;
   endfunction

endpackage

// ----- hdl/lvbs_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module lvbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/lvbs_cursor.sv -----
// Dimension registers and raster position counter with slice ring address.
module lvbs_cursor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [lvbs_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [lvbs_pkg::DIM_BITS-1:0]     csr_wr_data,
   input  logic                              step,
   output lvbs_pkg::pos_type                 pos,
   output lvbs_pkg::dims_type                dims
);
   import lvbs_pkg::*;

   dims_type dims_ff;
   dims_type dims_in;
   pos_type  pos_ff;
   pos_type  pos_in;
   logic     restart;
   logic     x_end;
   logic     y_end;
   logic     z_end;

   always_comb begin
      dims_in = dims_ff;
      restart = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DIM_X: begin
               dims_in.x = clamp_dim(csr_wr_data);
               restart   = 1'b1;
            end
            CSR_DIM_Y: begin
               dims_in.y = clamp_dim(csr_wr_data);
               restart   = 1'b1;
            end
            CSR_DIM_Z: begin
               dims_in.z = clamp_dim(csr_wr_data);
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   assign x_end = (DIM_BITS'(pos_ff.x) + DIM_BITS'(1)) >= dims_ff.x;
   assign y_end = (DIM_BITS'(pos_ff.y) + DIM_BITS'(1)) >= dims_ff.y;
   assign z_end = (DIM_BITS'(pos_ff.z) + DIM_BITS'(1)) >= dims_ff.z;

   always_comb begin
      pos_in = pos_ff;
      if (restart) begin
         pos_in = '0;
      end else if (step) begin
         pos_in.addr = pos_ff.addr + RING_ADDR_BITS'(1);
         if (x_end) begin
            pos_in.x = '0;
            if (y_end) begin
               pos_in.y    = '0;
               pos_in.addr = '0;
               pos_in.z    = z_end ? '0 : pos_ff.z + COORD_BITS'(1);
            end else begin
               pos_in.y = pos_ff.y + COORD_BITS'(1);
            end
         end else begin
            pos_in.x = pos_ff.x + COORD_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= '{x: DIM_MAX, y: DIM_MAX, z: DIM_MAX};
         pos_ff  <= '0;
      end else begin
         dims_ff <= dims_in;
         pos_ff  <= pos_in;
      end
   end

   assign pos  = pos_ff;
   assign dims = dims_ff;

endmodule

// ----- hdl/lvbs_marks.sv -----
// Present and shared-boundary mark arrays with neighbor touch logic.
module lvbs_marks (
   input  logic                   clock,
   input  logic                   reset,
   input  lvbs_pkg::mark_cmd_type cmd,
   output logic                   present,
   output logic                   shared
);
   import lvbs_pkg::*;

   logic [LABEL_COUNT-1:0] present_ff;
   logic [LABEL_COUNT-1:0] present_in;
   logic [LABEL_COUNT-1:0] shared_ff;
   logic [LABEL_COUNT-1:0] shared_in;
   logic                   hit_left;
   logic                   hit_up;
   logic                   hit_prev;
   logic                   live;

   assign live     = cmd.label != LABEL_NONE;
   assign hit_left = cmd.left_ok && live && cmd.left != LABEL_NONE && cmd.left != cmd.label;
   assign hit_up   = cmd.up_ok && live && cmd.up != LABEL_NONE && cmd.up != cmd.label;
   assign hit_prev = cmd.prev_ok && live && cmd.prev != LABEL_NONE && cmd.prev != cmd.label;

   always_comb begin
      present_in = present_ff;
      shared_in  = shared_ff;
      if (cmd.scan) begin
         present_in[cmd.label] = 1'b1;
         // first occurrence restarts the mark before this voxel's touches
         if (!present_ff[cmd.label]) begin
            shared_in[cmd.label] = 1'b0;
         end
         if (hit_left) begin
            shared_in[cmd.label] = 1'b1;
            shared_in[cmd.left]  = 1'b1;
         end
         if (hit_up) begin
            shared_in[cmd.label] = 1'b1;
            shared_in[cmd.up]    = 1'b1;
         end
         if (hit_prev) begin
            shared_in[cmd.label] = 1'b1;
            shared_in[cmd.prev]  = 1'b1;
         end
      end else if (cmd.clear) begin
         present_in[cmd.label] = 1'b0;
         shared_in[cmd.label]  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         shared_ff  <= '0;
      end else begin
         present_ff <= present_in;
         shared_ff  <= shared_in;
      end
   end

   assign present = present_ff[cmd.label];
   assign shared  = shared_ff[cmd.label];

endmodule

// ----- hdl/label_volume_bounds_scan.sv -----
// Top level of the label volume bounds scanner: sequencer, box update and result register.
//
// In the accept cycle the box memory, the slice ring and the row line memory are read at
// the label and the current raster position; in ST_EXEC a voxel item updates the box and
// writes it back, stores its label in the ring and the line, updates the marks and
// advances the position, while a read item registers the result and clears its marks. The
// box read-modify-write through its single port pair sets this split. A read item stays
// in ST_EXEC while an earlier result has not been taken. The ring and line memories are
// only read where the current volume has written them, so no clearing pass follows reset.
module label_volume_bounds_scan (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic [7:0]                        req_label,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_entry_label,
   output logic                              rsp_present,
   output logic [7:0]                        rsp_min_x,
   output logic [7:0]                        rsp_min_y,
   output logic [7:0]                        rsp_min_z,
   output logic [7:0]                        rsp_max_x,
   output logic [7:0]                        rsp_max_y,
   output logic [7:0]                        rsp_max_z,
   output logic                              rsp_shared_boundary,
   input  logic                              csr_wr_en,
   input  logic [lvbs_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [lvbs_pkg::DIM_BITS-1:0]     csr_wr_data
);
   import lvbs_pkg::*;

   state_type             state_ff;
   state_type             state_in;
   logic                  op_ff;
   logic [LABEL_BITS-1:0] lab_ff;
   logic [LABEL_BITS-1:0] left_ff;
   logic                  rsp_valid_ff;
   logic [LABEL_BITS-1:0] rsp_label_ff;
   logic                  rsp_present_ff;
   box_type               rsp_box_ff;
   logic                  rsp_shared_ff;

   logic                  accept;
   logic                  exec_done;
   logic                  scan_done;
   logic                  read_done;
   pos_type               pos;
   dims_type              dims;
   mark_cmd_type          mk_cmd;
   logic                  mk_present;
   logic                  mk_shared;
   logic [BOX_BITS-1:0]   box_rd_bits;
   box_type               box_rd;
   box_type               box_wr;
   logic [LABEL_BITS-1:0] ring_rd;
   logic [LABEL_BITS-1:0] line_rd;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      exec_done = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_EXEC: begin
            exec_done = (op_ff == OP_VOXEL) || !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign accept    = req_valid && req_ready;
   assign scan_done = exec_done && (op_ff == OP_VOXEL);
   assign read_done = exec_done && (op_ff == OP_READ);

   lvbs_cursor u_cursor (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .step        (scan_done),
      .pos         (pos),
      .dims        (dims)
   );

   lvbs_ram #(.WIDTH(BOX_BITS), .DEPTH(LABEL_COUNT)) u_box_ram (
      .clock   (clock),
      .wr_en   (scan_done),
      .wr_addr (lab_ff),
      .wr_data (box_wr),
      .rd_en   (accept),
      .rd_addr (req_label),
      .rd_data (box_rd_bits)
   );

   lvbs_ram #(.WIDTH(LABEL_BITS), .DEPTH(RING_DEPTH)) u_ring_ram (
      .clock   (clock),
      .wr_en   (scan_done),
      .wr_addr (pos.addr),
      .wr_data (lab_ff),
      .rd_en   (accept),
      .rd_addr (pos.addr),
      .rd_data (ring_rd)
   );

   lvbs_ram #(.WIDTH(LABEL_BITS), .DEPTH(MAX_DIM)) u_line_ram (
      .clock   (clock),
      .wr_en   (scan_done),
      .wr_addr (pos.x),
      .wr_data (lab_ff),
      .rd_en   (accept),
      .rd_addr (pos.x),
      .rd_data (line_rd)
   );

   assign mk_cmd = '{
      scan:    scan_done,
      clear:   read_done,
      label:   lab_ff,
      left:    left_ff,
      up:      line_rd,
      prev:    ring_rd,
      left_ok: pos.x != '0,
      up_ok:   pos.y != '0,
      prev_ok: pos.z != '0
   };

   lvbs_marks u_marks (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mk_cmd),
      .present (mk_present),
      .shared  (mk_shared)
   );

   assign box_rd = box_type'(box_rd_bits);

   always_comb begin
      if (!mk_present) begin
         box_wr = '{lo_x: pos.x, lo_y: pos.y, lo_z: pos.z,
                    hi_x: pos.x, hi_y: pos.y, hi_z: pos.z};
      end else begin
         box_wr.lo_x = (pos.x < box_rd.lo_x) ? pos.x : box_rd.lo_x;
         box_wr.lo_y = (pos.y < box_rd.lo_y) ? pos.y : box_rd.lo_y;
         box_wr.lo_z = (pos.z < box_rd.lo_z) ? pos.z : box_rd.lo_z;
         box_wr.hi_x = (pos.x > box_rd.hi_x) ? pos.x : box_rd.hi_x;
         box_wr.hi_y = (pos.y > box_rd.hi_y) ? pos.y : box_rd.hi_y;
         box_wr.hi_z = (pos.z > box_rd.hi_z) ? pos.z : box_rd.hi_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (read_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_operation;
         lab_ff <= req_label;
      end
      if (scan_done) begin
         left_ff <= lab_ff;
      end
      if (read_done) begin
         rsp_label_ff   <= lab_ff;
         rsp_present_ff <= mk_present;
         rsp_box_ff     <= mk_present ? box_rd : '0;
         rsp_shared_ff  <= mk_present && mk_shared;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_entry_label     = rsp_label_ff;
   assign rsp_present         = rsp_present_ff;
   assign rsp_min_x           = rsp_box_ff.lo_x;
   assign rsp_min_y           = rsp_box_ff.lo_y;
   assign rsp_min_z           = rsp_box_ff.lo_z;
   assign rsp_max_x           = rsp_box_ff.hi_x;
   assign rsp_max_y           = rsp_box_ff.hi_y;
   assign rsp_max_z           = rsp_box_ff.hi_z;
   assign rsp_shared_boundary = rsp_shared_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("item accepted while previous item still executing");

   a_read_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      read_done |=> rsp_valid)
      else $error("read item finished without a result");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      read_done |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_pos_in_volume: assert property (@(posedge clock) disable iff (reset)
      (DIM_BITS'(pos.x) < dims.x) && (DIM_BITS'(pos.y) < dims.y)
         && (DIM_BITS'(pos.z) < dims.z))
      else $error("raster position outside configured volume");
`endif

endmodule
